[sv/range_up_down_ratio_core_defines.svh]
// assertion macros for the range up/down ratio core checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef RANGE_UP_DOWN_RATIO_CORE_DEFINES_SVH
`define RANGE_UP_DOWN_RATIO_CORE_DEFINES_SVH

// checked only outside reset
`define RUDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define RUDR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rudr_pkg.sv]
// shared constants and types for the range up/down ratio core
// no dependencies
package rudr_pkg;

    localparam int PRICE_BITS    = 32;
    localparam int SUM_BITS      = 48;
    localparam int RATIO_BITS    = 40;
    localparam int FRACTION_BITS = 16;
    localparam int INT_BITS      = RATIO_BITS - FRACTION_BITS;
    localparam int WIDE_BITS     = SUM_BITS + INT_BITS;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int STEP_BITS     = $clog2(RATIO_BITS);

    typedef logic [SUM_BITS-1:0] sum_t;

    // the two sums of one finished series
    typedef struct packed {
        sum_t up_sum;
        sum_t down_sum;
    } job_t;

endpackage

[sv/range_up_down_ratio_core.sv]
// bars are taken one per cycle while in_ready is high; the sums update in the cycle the bar is accepted.
// a last bar queues its sums; the divider skips its restoring steps when the down sum
// is zero or the ratio saturates, and otherwise gives one quotient bit per cycle.
// in_ready drops only while the 4-entry series queue is full, i.e. when series come
// faster than the divider or the receiver holds off. asynchronous active-low reset clears
// the previous price, both sums, the queue and the divider.
module range_up_down_ratio_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rudr_pkg::PRICE_BITS-1:0] price,
    input  logic                           price_ok,
    input  logic [rudr_pkg::PRICE_BITS-1:0] bar_high,
    input  logic                           high_ok,
    input  logic [rudr_pkg::PRICE_BITS-1:0] bar_low,
    input  logic                           low_ok,
    input  logic                           first_bar,
    input  logic                           last_bar,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rudr_pkg::RATIO_BITS-1:0] ratio,
    output logic                           ratio_undefined,
    output logic                           ratio_saturated
);
    import rudr_pkg::*;

    logic push;
    logic queue_full;
    logic pop;
    logic job_valid;
    job_t push_data;
    job_t job;

    rudr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .price      (price),
        .price_ok   (price_ok),
        .bar_high   (bar_high),
        .high_ok    (high_ok),
        .bar_low    (bar_low),
        .low_ok     (low_ok),
        .first_bar  (first_bar),
        .last_bar   (last_bar),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    rudr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (job_valid),
        .pop_data  (job)
    );

    rudr_divider u_divider (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job             (job),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ratio           (ratio),
        .ratio_undefined (ratio_undefined),
        .ratio_saturated (ratio_saturated)
    );

endmodule

[sv/rudr_queue.sv]
// short queue of finished series between the bar front end and the divider
// depends on rudr_pkg
module rudr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rudr_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output rudr_pkg::job_t pop_data
);
    import rudr_pkg::*;

    job_t                mem_reg [QUEUE_DEPTH];
    job_t                pop_data_reg;
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full        = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty   = (count_reg != '0);
    assign do_push     = push && !full;
    assign do_pop      = pop && not_empty;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign pop_data    = pop_data_reg;

    // head item is registered; an item written into the head slot goes straight through
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next))
        begin
            pop_data_reg <= push_data;
        end
        else
        begin
            pop_data_reg <= mem_reg[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            rd_ptr_reg <= rd_ptr_next;
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[sv/rudr_front.sv]
// bar front end: classifies each bar and keeps the saturating up and down range sums
// depends on rudr_pkg; hands finished series to rudr_queue
module rudr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rudr_pkg::PRICE_BITS-1:0] price,
    input  logic                           price_ok,
    input  logic [rudr_pkg::PRICE_BITS-1:0] bar_high,
    input  logic                           high_ok,
    input  logic [rudr_pkg::PRICE_BITS-1:0] bar_low,
    input  logic                           low_ok,
    input  logic                           first_bar,
    input  logic                           last_bar,
    input  logic                           queue_full,
    output logic                           push,
    output rudr_pkg::job_t                 push_data
);
    import rudr_pkg::*;

    logic [PRICE_BITS-1:0] previous_price_reg;
    logic                  previous_ok_reg;
    sum_t                  up_sum_reg;
    sum_t                  down_sum_reg;
    sum_t                  up_sum_next;
    sum_t                  down_sum_next;

    logic                  accept;
    logic                  counts;
    logic [PRICE_BITS-1:0] bar_range;
    logic [SUM_BITS:0]     up_add;
    logic [SUM_BITS:0]     down_add;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign counts    = previous_ok_reg && price_ok && high_ok && low_ok && (bar_high > bar_low);
    assign bar_range = bar_high - bar_low;
    assign up_add    = {1'b0, up_sum_reg} + (SUM_BITS+1)'(bar_range);
    assign down_add  = {1'b0, down_sum_reg} + (SUM_BITS+1)'(bar_range);

    always_comb
    begin
        up_sum_next   = up_sum_reg;
        down_sum_next = down_sum_reg;
        priority if (first_bar)
        begin
            up_sum_next   = '0;
            down_sum_next = '0;
        end
        else if (counts && (price > previous_price_reg))
        begin
            up_sum_next = up_add[SUM_BITS] ? '1 : up_add[SUM_BITS-1:0];
        end
        else if (counts && (price < previous_price_reg))
        begin
            down_sum_next = down_add[SUM_BITS] ? '1 : down_add[SUM_BITS-1:0];
        end
    end

    // last bar queues the sums as they stand after this bar
    assign push               = accept && last_bar;
    assign push_data.up_sum   = up_sum_next;
    assign push_data.down_sum = down_sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_price_reg <= '0;
            previous_ok_reg    <= 1'b0;
            up_sum_reg         <= '0;
            down_sum_reg       <= '0;
        end
        else if (accept)
        begin
            previous_price_reg <= price;
            previous_ok_reg    <= price_ok;
            up_sum_reg         <= up_sum_next;
            down_sum_reg       <= down_sum_next;
        end
    end

endmodule

[sv/rudr_divider.sv]
// back end: restoring divider giving up_sum / down_sum as a saturating fixed-point ratio
// depends on rudr_pkg; takes jobs from rudr_queue
module rudr_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  rudr_pkg::job_t                 job,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rudr_pkg::RATIO_BITS-1:0] ratio,
    output logic                           ratio_undefined,
    output logic                           ratio_saturated
);
    import rudr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_OUT
    } state_t;

    state_t                state_reg;
    sum_t                  num_reg;
    sum_t                  den_reg;
    sum_t                  rem_reg;
    logic [RATIO_BITS-1:0] dvd_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [RATIO_BITS-1:0] ratio_reg;
    logic                  undefined_reg;
    logic                  saturated_reg;

    logic                  too_big;
    logic [SUM_BITS:0]     trial;
    logic                  fits;

    // integer part needs more than INT_BITS bits exactly when num >= den * 2^INT_BITS
    assign too_big = WIDE_BITS'(num_reg) >= (WIDE_BITS'(den_reg) << INT_BITS);
    assign trial   = {rem_reg, dvd_reg[RATIO_BITS-1]};
    assign fits    = trial >= {1'b0, den_reg};

    assign pop             = (state_reg == S_IDLE) && job_valid;
    assign out_valid       = (state_reg == S_OUT);
    assign ratio           = ratio_reg;
    assign ratio_undefined = undefined_reg;
    assign ratio_saturated = saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_reg       <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            dvd_reg       <= '0;
            step_reg      <= '0;
            ratio_reg     <= '0;
            undefined_reg <= 1'b0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        num_reg   <= job.up_sum;
                        den_reg   <= job.down_sum;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    undefined_reg <= 1'b0;
                    saturated_reg <= 1'b0;
                    priority if (den_reg == '0)
                    begin
                        undefined_reg <= 1'b1;
                        ratio_reg     <= '0;
                        state_reg     <= S_OUT;
                    end
                    else if (too_big)
                    begin
                        saturated_reg <= 1'b1;
                        ratio_reg     <= '1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        // top bits of num go to rem, below den here; low bits shifted by the fraction width to dvd
                        rem_reg   <= num_reg >> INT_BITS;
                        dvd_reg   <= RATIO_BITS'(num_reg[INT_BITS-1:0]) << FRACTION_BITS;
                        ratio_reg <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg   <= fits ? SUM_BITS'(trial - {1'b0, den_reg})
                                      : trial[SUM_BITS-1:0];
                    dvd_reg   <= dvd_reg << 1;
                    ratio_reg <= {ratio_reg[RATIO_BITS-2:0], fits};
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == STEP_BITS'(RATIO_BITS - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/rudr_checker.sv]
// port-level checks on the range up/down ratio core, bound to the top level
// depends on rudr_pkg and range_up_down_ratio_core_defines.svh
`include "range_up_down_ratio_core_defines.svh"

module rudr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [rudr_pkg::RATIO_BITS-1:0] ratio,
    input logic                           ratio_undefined,
    input logic                           ratio_saturated
);
    import rudr_pkg::*;

    // a waiting result item holds
    `RUDR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(ratio), "result item changed while stalled")

    // undefined ratio reads zero and is never also clamped
    `RUDR_ASSERT(a_undef_zero, out_valid && ratio_undefined |-> ratio == '0 && !ratio_saturated, "undefined ratio not zero")

    // a clamped ratio sits at full scale
    `RUDR_ASSERT(a_sat_max, out_valid && ratio_saturated |-> ratio == '1, "saturated ratio not at full scale")

    // no result item follows a sampled reset
    `RUDR_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "result item during reset")

endmodule

bind range_up_down_ratio_core rudr_checker u_rudr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ratio           (ratio),
    .ratio_undefined (ratio_undefined),
    .ratio_saturated (ratio_saturated)
);

[sim/tb_top.sv]
// testbench for range_up_down_ratio_core: bars in, up/down range ratios out
// predicts each ratio from its own copy of the sums and checks it field by field
// depends on rudr_pkg and range_up_down_ratio_core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rudr_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int STUCK_LIMIT = 2000;
    localparam int RANDOM_BARS = 1100;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic                  price_ok;
        logic [PRICE_BITS-1:0] bar_high;
        logic                  high_ok;
        logic [PRICE_BITS-1:0] bar_low;
        logic                  low_ok;
        logic                  first_bar;
        logic                  last_bar;
    } bar_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic                  undefined;
        logic                  saturated;
    } ratio_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PRICE_BITS-1:0] price = '0;
    logic                  price_ok = 1'b0;
    logic [PRICE_BITS-1:0] bar_high = '0;
    logic                  high_ok = 1'b0;
    logic [PRICE_BITS-1:0] bar_low = '0;
    logic                  low_ok = 1'b0;
    logic                  first_bar = 1'b0;
    logic                  last_bar = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [RATIO_BITS-1:0] ratio;
    logic                  ratio_undefined;
    logic                  ratio_saturated;

    // predicted series state
    logic [PRICE_BITS-1:0] prev_price = '0;
    logic                  prev_ok = 1'b0;
    sum_t                  up_total = '0;
    sum_t                  down_total = '0;
    ratio_t                ratio_due[$];

    int  mismatch_count = 0;
    int  stuck_cycles = 0;
    int  hold_cycles = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    always #HALF_PERIOD clk = ~clk;

    range_up_down_ratio_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .price           (price),
        .price_ok        (price_ok),
        .bar_high        (bar_high),
        .high_ok         (high_ok),
        .bar_low         (bar_low),
        .low_ok          (low_ok),
        .first_bar       (first_bar),
        .last_bar        (last_bar),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ratio           (ratio),
        .ratio_undefined (ratio_undefined),
        .ratio_saturated (ratio_saturated)
    );

    function automatic sum_t sum_add(sum_t acc, logic [PRICE_BITS-1:0] span);
        logic [SUM_BITS:0] s;
        s = {1'b0, acc} + span;
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

    // truncated up/down quotient in Q24.16, clamped to the ratio width
    function automatic ratio_t fixed_ratio(sum_t up, sum_t down);
        ratio_t r;
        logic [SUM_BITS+FRACTION_BITS-1:0] q;
        r = '0;
        if (down == '0)
        begin
            r.undefined = 1'b1;
        end
        else
        begin
            q = {up, {FRACTION_BITS{1'b0}}} / down;
            if ((q >> RATIO_BITS) != 0)
            begin
                r.ratio = '1;
                r.saturated = 1'b1;
            end
            else
            begin
                r.ratio = q[RATIO_BITS-1:0];
            end
        end
        return r;
    endfunction

    function automatic void track_bar(bar_t b);
        if (b.first_bar)
        begin
            up_total = '0;
            down_total = '0;
        end
        else if (prev_ok && b.price_ok && b.high_ok && b.low_ok && b.bar_high > b.bar_low)
        begin
            if (b.price > prev_price)
                up_total = sum_add(up_total, b.bar_high - b.bar_low);
            else if (b.price < prev_price)
                down_total = sum_add(down_total, b.bar_high - b.bar_low);
        end
        prev_price = b.price;
        prev_ok = b.price_ok;
        if (b.last_bar)
            ratio_due.push_back(fixed_ratio(up_total, down_total));
    endfunction

    function automatic bar_t mk_bar(logic [PRICE_BITS-1:0] p, bit pok,
                                    logic [PRICE_BITS-1:0] h, bit hok,
                                    logic [PRICE_BITS-1:0] l, bit lok, bit fst, bit lst);
        bar_t b;
        b.price = p;
        b.price_ok = pok;
        b.bar_high = h;
        b.high_ok = hok;
        b.bar_low = l;
        b.low_ok = lok;
        b.first_bar = fst;
        b.last_bar = lst;
        return b;
    endfunction

    function automatic bar_t random_bar(logic [PRICE_BITS-1:0] prev);
        bar_t b;
        logic [PRICE_BITS:0] top;
        int unsigned span;
        case ($urandom_range(0, 3))
            0: b.price = $urandom;
            1: b.price = prev + $urandom_range(1, 50);
            2: b.price = prev - $urandom_range(1, 50);
            default: b.price = prev;
        endcase
        b.bar_low = $urandom;
        case ($urandom_range(0, 7))
            0: b.bar_high = $urandom;
            1: b.bar_high = b.bar_low;
            default:
            begin
                span = $urandom_range(1, 5000);
                top = {1'b0, b.bar_low} + span;
                b.bar_high = top[PRICE_BITS] ? '1 : top[PRICE_BITS-1:0];
            end
        endcase
        b.price_ok = ($urandom_range(0, 15) != 0);
        b.high_ok = ($urandom_range(0, 15) != 0);
        b.low_ok = ($urandom_range(0, 15) != 0);
        b.first_bar = 1'b0;
        b.last_bar = 1'b0;
        return b;
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_bar(bar_t b);
        int gap;
        bit taken;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        price <= b.price;
        price_ok <= b.price_ok;
        bar_high <= b.bar_high;
        high_ok <= b.high_ok;
        bar_low <= b.bar_low;
        low_ok <= b.low_ok;
        first_bar <= b.first_bar;
        last_bar <= b.last_bar;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        track_bar(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ratio_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // extremes, every flag case, rounding, boundaries and missing first mark
    task automatic test_directed();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        // quotient of exactly 2^24 saturates
        send_bar(mk_bar(32'd0, 1, 32'd10, 1, 32'd5, 1, 1, 0));
        send_bar(mk_bar(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFEFF_FFFF, 1, 0, 0));
        send_bar(mk_bar(32'd0, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFE, 1, 0, 0));
        send_bar(mk_bar(32'd0, 1, 32'd7, 1, 32'd3, 1, 0, 1));
        // just below the clamp
        send_bar(mk_bar(32'd0, 1, 32'd4, 1, 32'd1, 1, 1, 0));
        send_bar(mk_bar(32'd1, 1, 32'h00FF_FFFF, 1, 32'd0, 1, 0, 0));
        send_bar(mk_bar(32'd0, 1, 32'd1, 1, 32'd0, 1, 0, 1));
        // first and last on one bar
        send_bar(mk_bar(32'd100, 1, 32'd200, 1, 32'd100, 1, 1, 1));
        send_bar(mk_bar(32'd150, 1, 32'd20, 1, 32'd10, 1, 1, 0));
        send_bar(mk_bar(32'd160, 1, 32'd13, 1, 32'd10, 1, 0, 0));
        send_bar(mk_bar(32'd150, 1, 32'd19, 1, 32'd10, 1, 0, 0));
        send_bar(mk_bar(32'd140, 0, 32'd50, 1, 32'd10, 1, 0, 0));
        // previous price invalid, then each flag low, flat range, reversed range
        send_bar(mk_bar(32'd120, 1, 32'd50, 1, 32'd10, 1, 0, 0));
        send_bar(mk_bar(32'd130, 1, 32'd50, 0, 32'd10, 1, 0, 0));
        send_bar(mk_bar(32'd140, 1, 32'd50, 1, 32'd10, 0, 0, 0));
        send_bar(mk_bar(32'd150, 1, 32'd10, 1, 32'd10, 1, 0, 0));
        send_bar(mk_bar(32'd100, 1, 32'd0, 1, 32'hFFFF_FFFF, 1, 0, 0));
        // 3 / 18 truncates
        send_bar(mk_bar(32'd90, 1, 32'd10, 1, 32'd1, 1, 0, 1));
        // no first mark: sums carry on, then a repeated last
        send_bar(mk_bar(32'd100, 1, 32'd2, 1, 32'd0, 1, 0, 0));
        send_bar(mk_bar(32'd95, 1, 32'hFFFF_FFFF, 1, 32'd0, 1, 0, 1));
        send_bar(mk_bar(32'd95, 1, 32'd9, 1, 32'd1, 1, 0, 1));
        // up only gives an undefined ratio
        send_bar(mk_bar(32'd5, 0, 32'd3, 1, 32'd1, 1, 1, 0));
        send_bar(mk_bar(32'd6, 1, 32'd9, 1, 32'd1, 1, 0, 0));
        send_bar(mk_bar(32'd7, 1, 32'd9, 1, 32'd1, 1, 0, 1));
        drain();
    endtask

    // receiver holds off while one-bar series keep coming, so the queue fills
    task automatic test_back_pressure();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        hold_cycles = 300;
        for (int i = 0; i < 30; i++)
        begin
            bar_t b;
            b = random_bar(prev_price);
            b.first_bar = 1'b1;
            b.last_bar = 1'b1;
            send_bar(b);
        end
        drain();
    endtask

    // mostly well-formed series with random content, some broken framing
    task automatic test_random();
        int sent;
        int len;
        bit broken;
        bar_t b;
        sent = 0;
        while (sent < RANDOM_BARS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 24);
            broken = ($urandom_range(0, 9) == 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
            begin
                b = random_bar(prev_price);
                b.first_bar = (i == 0) && !(broken && $urandom_range(0, 1));
                b.last_bar = (i == len - 1);
                if (broken && i != 0 && $urandom_range(0, 5) == 0)
                    b.last_bar = 1'b1;
                if (broken && i != 0 && $urandom_range(0, 9) == 0)
                    b.first_bar = 1'b1;
                send_bar(b);
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin : collect_ratios
        int stall;
        bit got;
        ratio_t seen;
        ratio_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = stalls_on ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            got = 1'b0;
            while (!got)
            begin
                @(negedge clk);
                got = out_valid;
                seen.ratio = ratio;
                seen.undefined = ratio_undefined;
                seen.saturated = ratio_saturated;
                @(posedge clk);
            end
            if (ratio_due.size() == 0)
            begin
                $display("%0t: unexpected item, ratio %h undefined %b saturated %b",
                         $time, seen.ratio, seen.undefined, seen.saturated);
                mismatch_count++;
            end
            else
            begin
                want = ratio_due.pop_front();
                if (seen.ratio !== want.ratio)
                begin
                    $display("%0t: ratio expected %h, got %h", $time, want.ratio, seen.ratio);
                    mismatch_count++;
                end
                if (seen.undefined !== want.undefined)
                begin
                    $display("%0t: ratio_undefined expected %b, got %b",
                             $time, want.undefined, seen.undefined);
                    mismatch_count++;
                end
                if (seen.saturated !== want.saturated)
                begin
                    $display("%0t: ratio_saturated expected %b, got %b",
                             $time, want.saturated, seen.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // cycles with no item moving on either side
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_pressure();
        test_random();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && ratio_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
